// ===== hdl/mrip_pkg.sv =====
// shared types and constants for the interval partitioning block
package mrip_pkg;
	localparam int MaxMeetings = 1024;
	localparam int AddrW = $clog2(MaxMeetings);
	localparam int CntW = $clog2(MaxMeetings + 1);
	localparam int TimeW = 31;
	localparam int RoomsW = 11;

	typedef struct packed {
		logic [TimeW-1:0] meeting_start;
		logic [TimeW-1:0] meeting_end;
		logic last_meeting;
	} mrip_in_t;

	typedef struct packed {
		logic [RoomsW-1:0] rooms_needed;
		logic capacity_overflow;
	} mrip_out_t;
endpackage

// ===== hdl/mrip_ram.sv =====
// generic single-port-write, one-read synchronous ram
module mrip_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/min_rooms_interval_partition.sv =====
// top level: interval loading with insertion sort and min-heap sweep
// Intervals are taken one beat at a time while busy is low. Each interval is
// insertion-sorted into the start/end stores: every loaded entry with a
// strictly greater start is read and moved up one place, then the new entry
// is written. On the beat marked last the sweep runs over the sorted set:
// each interval costs a store read, an optional heap pop (sift-down, reading
// both children per level) and a push (sift-up, reading the parent per
// level), all through single-read heap memory. The one result is strobed by
// done for one cycle; the receiver cannot stall it. Intervals beyond capacity
// are dropped and flagged.
module min_rooms_interval_partition (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mrip_pkg::mrip_in_t in_data,
	output logic done,
	output mrip_pkg::mrip_out_t out_data
);
	import mrip_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0, S_LRD = 5'd1, S_LCMP = 5'd2,
		S_SRD = 5'd3, S_SCMP = 5'd4, S_TOPRD = 5'd5, S_TOPCMP = 5'd6,
		S_PLAST = 5'd7, S_PLASTW = 5'd8, S_DRD_L = 5'd9, S_DRD_R = 5'd10,
		S_DCMP_L = 5'd11, S_DCMP_R = 5'd12, S_PUSH = 5'd13, S_URD = 5'd14,
		S_UCMP = 5'd15, S_NEXT = 5'd16, S_OUT = 5'd17;

	logic [4:0] state_q;
	logic [TimeW-1:0] s_q, e_q, cur_s_q, cur_e_q, best_v_q, pos_v_q;
	logic [CntW-1:0] loaded_q, fill_q, peak_q, idx_q;
	logic [AddrW-1:0] pos_q, best_q;
	logic dropped_q, last_q;

	// store rams (start and end written together)
	logic st_we, hp_we;
	logic [AddrW-1:0] st_wa, st_ra, hp_wa, hp_ra;
	logic [TimeW-1:0] ss_wd, se_wd, ss_rd, se_rd, hp_wd, hp_rd;

	mrip_ram #(.Width(TimeW), .Depth(MaxMeetings)) u_start (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(ss_wd), .raddr(st_ra), .rdata(ss_rd));
	mrip_ram #(.Width(TimeW), .Depth(MaxMeetings)) u_end (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(se_wd), .raddr(st_ra), .rdata(se_rd));
	mrip_ram #(.Width(TimeW), .Depth(MaxMeetings)) u_heap (
		.clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra), .rdata(hp_rd));

	logic [CntW:0] lc_w, rc_w;
	logic [AddrW-1:0] up_w;
	assign lc_w = {1'b0, pos_q, 1'b1};
	assign rc_w = lc_w + 1'b1;
	assign up_w = (pos_q - 1'b1) >> 1;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		st_we = 1'b0;
		st_wa = pos_q;
		ss_wd = s_q;
		se_wd = e_q;
		st_ra = pos_q - 1'b1;
		hp_we = 1'b0;
		hp_wa = pos_q;
		hp_wd = cur_e_q;
		hp_ra = pos_q;
		unique case (state_q)
			S_LCMP: begin
				// shift greater entry up one place, or drop new entry in
				st_we = 1'b1;
				if (pos_q != '0 && ss_rd > s_q) begin
					ss_wd = ss_rd;
					se_wd = se_rd;
				end
			end
			S_SRD: st_ra = idx_q[AddrW-1:0];
			S_TOPRD: hp_ra = '0;
			S_PLAST: hp_ra = AddrW'(fill_q - 1'b1);
			S_PLASTW: begin
				hp_we = 1'b1;
				hp_wa = '0;
				hp_wd = hp_rd;
			end
			S_DRD_L: hp_ra = lc_w[AddrW-1:0];
			S_DRD_R: hp_ra = rc_w[AddrW-1:0];
			S_DCMP_R: begin
				// move the smaller child up, or settle the sinking value here
				hp_we = 1'b1;
				hp_wa = pos_q;
				hp_wd = (best_q != pos_q) ? best_v_q : pos_v_q;
			end
			S_PUSH: begin
				hp_we = 1'b1;
				hp_wa = AddrW'(fill_q);
			end
			S_URD: hp_ra = up_w;
			S_UCMP: begin
				// move the parent down, or settle the new end here
				hp_we = 1'b1;
				hp_wa = pos_q;
				if (pos_q != '0 && hp_rd > cur_e_q) begin
					hp_wd = hp_rd;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loaded_q <= '0;
			fill_q <= '0;
			peak_q <= '0;
			idx_q <= '0;
			dropped_q <= 1'b0;
			last_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= (state_q == S_OUT);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						s_q <= in_data.meeting_start;
						e_q <= in_data.meeting_end;
						last_q <= in_data.last_meeting;
						pos_q <= AddrW'(loaded_q);
						if (loaded_q < CntW'(MaxMeetings)) begin
							state_q <= S_LRD;
						end else begin
							dropped_q <= 1'b1;
							state_q <= in_data.last_meeting ? S_SRD : S_IDLE;
							idx_q <= '0;
							fill_q <= '0;
							peak_q <= '0;
						end
					end
				end
				S_LRD: state_q <= S_LCMP;
				S_LCMP: begin
					if (pos_q != '0 && ss_rd > s_q) begin
						pos_q <= pos_q - 1'b1;
						state_q <= S_LRD;
					end else begin
						loaded_q <= loaded_q + 1'b1;
						idx_q <= '0;
						fill_q <= '0;
						peak_q <= '0;
						state_q <= last_q ? S_SRD : S_IDLE;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					cur_s_q <= ss_rd;
					cur_e_q <= se_rd;
					state_q <= (fill_q != '0) ? S_TOPRD : S_PUSH;
				end
				S_TOPRD: state_q <= S_TOPCMP;
				S_TOPCMP: state_q <= (cur_s_q >= hp_rd) ? S_PLAST : S_PUSH;
				S_PLAST: state_q <= S_PLASTW;
				S_PLASTW: begin
					// last entry now at root, sift it down
					fill_q <= fill_q - 1'b1;
					pos_q <= '0;
					pos_v_q <= hp_rd;
					state_q <= S_DRD_L;
				end
				S_DRD_L: begin
					best_q <= pos_q;
					best_v_q <= pos_v_q;
					state_q <= S_DRD_R;
				end
				S_DRD_R: begin
					if (lc_w < {1'b0, fill_q} && hp_rd < best_v_q) begin
						best_q <= lc_w[AddrW-1:0];
						best_v_q <= hp_rd;
					end
					state_q <= S_DCMP_L;
				end
				S_DCMP_L: begin
					if (rc_w < {1'b0, fill_q} && hp_rd < best_v_q) begin
						best_q <= rc_w[AddrW-1:0];
						best_v_q <= hp_rd;
					end
					state_q <= S_DCMP_R;
				end
				S_DCMP_R: begin
					if (best_q == pos_q) begin
						state_q <= S_PUSH;
					end else begin
						pos_q <= best_q;
						state_q <= S_DRD_L;
					end
				end
				S_PUSH: begin
					// new end lands at its slot when the sift-up settles
					pos_q <= AddrW'(fill_q);
					fill_q <= fill_q + 1'b1;
					if (fill_q + 1'b1 > peak_q) begin
						peak_q <= fill_q + 1'b1;
					end
					state_q <= (fill_q != '0) ? S_URD : S_NEXT;
				end
				S_URD: state_q <= S_UCMP;
				S_UCMP: begin
					if (pos_q != '0 && hp_rd > cur_e_q) begin
						pos_q <= up_w;
						state_q <= S_URD;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (idx_q + 1'b1 < loaded_q) begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_data.rooms_needed <= RoomsW'(peak_q);
					out_data.capacity_overflow <= dropped_q;
					loaded_q <= '0;
					fill_q <= '0;
					peak_q <= '0;
					dropped_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= loaded_q) else $error("heap larger than set");
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= peak_q || state_q == S_PUSH) else $error("peak below fill");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done outside idle");
`endif
endmodule
